/* src/jfs_pkg.sv */
// Shared constants for the five-point Jacobi sweep block.
package jfs_pkg;

  // Default build parameters
  localparam int MAX_COLS_DEF   = 1024;
  localparam int VALUE_BITS_DEF = 32;

  // Fixed field widths
  localparam int ROW_W      = 16;
  localparam int GCOL_W     = 11;
  localparam int CHG_W      = 31;
  localparam int CFG_DATA_W = 31;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 2'd2;

  // Register reset values
  localparam logic [ROW_W-1:0]  GRID_ROWS_RST = 16'd1024;
  localparam logic [GCOL_W-1:0] GRID_COLS_RST = 11'd1024;
  localparam logic [CHG_W-1:0]  TOLERANCE_RST = 31'd17;

  // Largest reportable change
  localparam logic [CHG_W-1:0] CHANGE_MAX = {CHG_W{1'b1}};

endpackage

/* src/jfs_cell.sv */
// Pipeline cell: one payload slot with valid/stall flow control.
module jfs_cell #(
  parameter type T = logic
) (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  input  T     up_data,
  output logic up_stall,
  output logic dn_valid,
  output T     dn_data,
  input  logic dn_stall
);

  logic valid_r;
  logic valid_nxt;
  T     data_r;
  logic load;

  // Slot is busy only when it holds a transaction that cannot move on
  assign up_stall = valid_r && dn_stall;
  assign load     = up_valid && !up_stall;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (dn_stall) begin
      valid_nxt = valid_r;
    end else begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= up_data;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

/* src/jfs_line_store.sv */
// Line store: one write and one registered read per cycle, write-first on collision.
module jfs_line_store #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read returns the word being written when addresses match
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/jacobi_five_point_sweep.sv */
// Throughput: one cell per cycle unless out_stall backs up the cell chain, set by the single
// read port of the line store (one word a cycle).
// The stencil path is a chain of four cells: window, quarter sum, change, running maximum.
// Reset (rst_n low, synchronous) restores the registers and clears positions and the maximum;
// line stores are not cleared and no clearing pass runs, so cells are taken right after reset.
module jacobi_five_point_sweep
  import jfs_pkg::*;
#(
  parameter int MAX_COLS   = MAX_COLS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [VALUE_BITS-1:0]  in_cell_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [VALUE_BITS-1:0]  out_new_value,
  output logic [ROW_W-1:0]              out_row_index,
  output logic [$clog2(MAX_COLS)-1:0]   out_col_index,
  output logic [CHG_W-1:0]              out_cell_change,
  output logic [CHG_W-1:0]              out_max_change,
  output logic                          out_last_of_sweep,
  output logic                          out_keep_iterating
);

  localparam int VB    = VALUE_BITS;
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int CNT_W = ($clog2(MAX_COLS + 1) > GCOL_W) ? $clog2(MAX_COLS + 1) : GCOL_W;
  localparam int SUM_W = VB + 2;
  localparam int MAG_W = VB + 1;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum3;
    logic signed [VB-1:0]    centre;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic                    last;
  } a_t;

  typedef struct packed {
    logic signed [VB-1:0] nv;
    logic signed [VB-1:0] centre;
    logic [ROW_W-1:0]     row;
    logic [COL_W-1:0]     col;
    logic                 last;
  } b_t;

  typedef struct packed {
    logic signed [VB-1:0] nv;
    logic [CHG_W-1:0]     chg;
    logic [ROW_W-1:0]     row;
    logic [COL_W-1:0]     col;
    logic                 last;
  } c_t;

  typedef struct packed {
    logic signed [VB-1:0] nv;
    logic [CHG_W-1:0]     chg;
    logic [CHG_W-1:0]     maxc;
    logic [ROW_W-1:0]     row;
    logic [COL_W-1:0]     col;
    logic                 last;
    logic                 keep;
  } d_t;

  // Configuration and sweep state
  logic [ROW_W-1:0]     grid_rows_r;
  logic [GCOL_W-1:0]    grid_cols_r;
  logic [CHG_W-1:0]     tolerance_r;
  logic [ROW_W-1:0]     row_pos_r;
  logic [ROW_W-1:0]     row_pos_nxt;
  logic [COL_W-1:0]     col_pos_r;
  logic [COL_W-1:0]     col_pos_nxt;
  logic signed [VB-1:0] left_r;
  logic signed [VB-1:0] left_nxt;
  logic [CHG_W-1:0]     sweep_max_r;
  logic [CHG_W-1:0]     sweep_max_nxt;

  logic             geo_wr;
  logic             accept;
  logic [CNT_W-1:0] cols_eff;
  logic [CNT_W:0]   cols_x;
  logic [CNT_W:0]   col_p1;
  logic [CNT_W:0]   col_p2;
  logic             col_wrap;
  logic [ROW_W:0]   row_p1;
  logic             row_wrap;
  logic             produce;
  logic             last_cell;

  // Line store signals
  logic [2*VB-1:0]      ls_rdata;
  logic [2*VB-1:0]      ls_wdata;
  logic [COL_W-1:0]     ls_raddr;
  logic signed [VB-1:0] centre;
  logic signed [VB-1:0] above;
  logic signed [VB-1:0] right;

  // Cell chain
  a_t   a_in, a_q;
  b_t   b_in, b_q;
  c_t   c_in, c_q;
  d_t   d_in, d_q;
  logic a_valid, b_valid, c_valid;
  logic b_up_stall, c_up_stall, d_up_stall;
  logic d_load;

  logic signed [SUM_W-1:0] sum4;
  logic signed [MAG_W-1:0] d_pos;
  logic signed [MAG_W-1:0] d_neg;
  logic [MAG_W-1:0]        mag;
  logic [CHG_W-1:0]        chg_sat;
  logic                    chg_gt_max;

  assign geo_wr = cfg_we && ((cfg_index == REG_GRID_ROWS) || (cfg_index == REG_GRID_COLS));
  assign accept = in_valid && !in_stall;

  // Effective column count and position bookkeeping
  assign cols_eff  = (CNT_W'(grid_cols_r) < CNT_W'(MAX_COLS)) ? CNT_W'(grid_cols_r)
                                                               : CNT_W'(MAX_COLS);
  assign cols_x    = (CNT_W + 1)'(cols_eff);
  assign col_p1    = (CNT_W + 1)'(col_pos_r) + 1'b1;
  assign col_p2    = col_p1 + 1'b1;
  assign col_wrap  = col_p1 >= cols_x;
  assign row_p1    = (ROW_W + 1)'(row_pos_r) + 1'b1;
  assign row_wrap  = row_p1 >= (ROW_W + 1)'(grid_rows_r);
  assign produce   = (row_pos_r >= ROW_W'(2)) && (col_pos_r != '0) && (col_p2 <= cols_x);
  assign last_cell = (row_p1 == (ROW_W + 1)'(grid_rows_r)) && (col_p2 == cols_x);

  always_comb begin
    row_pos_nxt   = row_pos_r;
    col_pos_nxt   = col_pos_r;
    left_nxt      = left_r;
    sweep_max_nxt = sweep_max_r;
    if (geo_wr) begin
      row_pos_nxt   = '0;
      col_pos_nxt   = '0;
      left_nxt      = '0;
      sweep_max_nxt = '0;
    end else begin
      if (accept) begin
        if (col_wrap) begin
          col_pos_nxt = '0;
          left_nxt    = '0;
          row_pos_nxt = row_wrap ? '0 : row_p1[ROW_W-1:0];
        end else begin
          col_pos_nxt = col_pos_r + 1'b1;
          left_nxt    = centre;
        end
      end
      if (d_load) begin
        sweep_max_nxt = c_q.last ? '0 : d_in.maxc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= GRID_ROWS_RST;
      grid_cols_r <= GRID_COLS_RST;
      tolerance_r <= TOLERANCE_RST;
      row_pos_r   <= '0;
      col_pos_r   <= '0;
      left_r      <= '0;
      sweep_max_r <= '0;
    end else begin
      row_pos_r   <= row_pos_nxt;
      col_pos_r   <= col_pos_nxt;
      left_r      <= left_nxt;
      sweep_max_r <= sweep_max_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GRID_ROWS: grid_rows_r <= cfg_wdata[ROW_W-1:0];
          REG_GRID_COLS: grid_cols_r <= cfg_wdata[GCOL_W-1:0];
          REG_TOLERANCE: tolerance_r <= cfg_wdata[CHG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Line store: upper half is two rows back, lower half one row back.
  // The read port always holds the word for the next cell's column.
  assign centre   = ls_rdata[VB-1:0];
  assign above    = ls_rdata[2*VB-1:VB];
  assign right    = ls_rdata[VB-1:0];
  assign ls_wdata = {centre, in_cell_value};

  always_comb begin
    if (!rst_n || geo_wr) begin
      ls_raddr = '0;
    end else if (accept) begin
      ls_raddr = col_pos_nxt;
    end else begin
      ls_raddr = col_pos_r;
    end
  end

  jfs_line_store #(
    .DEPTH(MAX_COLS),
    .WIDTH(2 * VB)
  ) u_line_store (
    .clk  (clk),
    .we   (accept),
    .waddr(col_pos_r),
    .wdata(ls_wdata),
    .raddr(ls_raddr),
    .rdata(ls_rdata)
  );

  // Window cell: three of four neighbors summed on entry
  always_comb begin
    a_in.sum3   = SUM_W'(left_r) + SUM_W'(above) + SUM_W'(in_cell_value);
    a_in.centre = centre;
    a_in.row    = row_pos_r - 1'b1;
    a_in.col    = col_pos_r;
    a_in.last   = last_cell;
  end

  jfs_cell #(.T(a_t)) u_cell_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_valid(in_valid && produce),
    .up_data (a_in),
    .up_stall(in_stall),
    .dn_valid(a_valid),
    .dn_data (a_q),
    .dn_stall(b_up_stall)
  );

  // Quarter of the neighbor sum; the right neighbor sits on the read port
  // while the window cell is occupied, since a transaction enters only as it moves on.
  assign sum4 = $signed(a_q.sum3) + SUM_W'(right);

  always_comb begin
    b_in.nv     = VB'(sum4 >>> 2);
    b_in.centre = a_q.centre;
    b_in.row    = a_q.row;
    b_in.col    = a_q.col;
    b_in.last   = a_q.last;
  end

  jfs_cell #(.T(b_t)) u_cell_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_valid(a_valid),
    .up_data (b_in),
    .up_stall(b_up_stall),
    .dn_valid(b_valid),
    .dn_data (b_q),
    .dn_stall(c_up_stall)
  );

  // Absolute change, both differences formed side by side
  assign d_pos = MAG_W'($signed(b_q.nv)) - MAG_W'($signed(b_q.centre));
  assign d_neg = MAG_W'($signed(b_q.centre)) - MAG_W'($signed(b_q.nv));
  assign mag   = d_pos[MAG_W-1] ? d_neg : d_pos;

  generate
    if (MAG_W > CHG_W) begin : g_sat
      assign chg_sat = (|mag[MAG_W-1:CHG_W]) ? CHANGE_MAX : mag[CHG_W-1:0];
    end else begin : g_nosat
      assign chg_sat = CHG_W'(mag);
    end
  endgenerate

  always_comb begin
    c_in.nv   = b_q.nv;
    c_in.chg  = chg_sat;
    c_in.row  = b_q.row;
    c_in.col  = b_q.col;
    c_in.last = b_q.last;
  end

  jfs_cell #(.T(c_t)) u_cell_c (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_valid(b_valid),
    .up_data (c_in),
    .up_stall(c_up_stall),
    .dn_valid(c_valid),
    .dn_data (c_q),
    .dn_stall(d_up_stall)
  );

  // Running maximum and convergence flag, into the output cell
  assign chg_gt_max = c_q.chg > sweep_max_r;
  assign d_load     = c_valid && !d_up_stall;

  always_comb begin
    d_in.nv   = c_q.nv;
    d_in.chg  = c_q.chg;
    d_in.maxc = chg_gt_max ? c_q.chg : sweep_max_r;
    d_in.row  = c_q.row;
    d_in.col  = c_q.col;
    d_in.last = c_q.last;
    d_in.keep = c_q.last && (chg_gt_max ? (c_q.chg > tolerance_r)
                                        : (sweep_max_r > tolerance_r));
  end

  jfs_cell #(.T(d_t)) u_cell_d (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_valid(c_valid),
    .up_data (d_in),
    .up_stall(d_up_stall),
    .dn_valid(out_valid),
    .dn_data (d_q),
    .dn_stall(out_stall)
  );

  assign out_new_value      = d_q.nv;
  assign out_row_index      = d_q.row;
  assign out_col_index      = d_q.col;
  assign out_cell_change    = d_q.chg;
  assign out_max_change     = d_q.maxc;
  assign out_last_of_sweep  = d_q.last;
  assign out_keep_iterating = d_q.keep;

`ifndef SYNTHESIS
  // Convergence flag only comes with the final cell
  a_keep_with_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_keep_iterating |-> out_last_of_sweep)
    else $error("keep_iterating without last_of_sweep");

  // Running maximum covers the cell's own change
  a_max_covers_cell: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_max_change >= out_cell_change)
    else $error("max_change below cell_change");

  // Maximum restarts after the final cell of a sweep
  a_max_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    d_load && c_q.last |=> sweep_max_r == '0)
    else $error("sweep maximum not cleared after last cell");

  // Column position stays inside the grid
  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W'(col_pos_r) < cols_eff) || (col_pos_r == '0))
    else $error("column position out of range");

  // A transaction that completes a stencil enters the window cell
  a_window_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    accept && produce |=> a_valid)
    else $error("stencil transaction lost at window cell");
`endif

endmodule
